// File: rtl/core/sc2a_pkg.sv
package sc2a_pkg;

  localparam int unsigned CodeW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned KindW    = 3;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned FlagDepth = 2;

  localparam logic [CodeW-1:0] CodePrefix  = 8'hE0;
  localparam logic [CodeW-1:0] CodeRelBit  = 8'h80;
  localparam logic [CodeW-1:0] CodeKeyMask = 8'h7F;
  localparam logic [CodeW-1:0] CodeLShift  = 8'h2A;
  localparam logic [CodeW-1:0] CodeRShift  = 8'h36;
  localparam logic [CodeW-1:0] CodeCaps    = 8'h3A;
  localparam logic [CodeW-1:0] CodeUp      = 8'h48;
  localparam logic [CodeW-1:0] CodeDown    = 8'h50;
  localparam logic [CodeW-1:0] CodeLeft    = 8'h4B;
  localparam logic [CodeW-1:0] CodeRight   = 8'h4D;
  localparam logic [CodeW-1:0] CodeDelete  = 8'h53;
  localparam logic [CodeW-1:0] TableLen    = 8'd59;
  localparam logic [CharW-1:0] CaseDelta   = 7'd32;

  typedef enum logic [KindW-1:0] {
    KIND_CHAR   = 3'd0,
    KIND_UP     = 3'd1,
    KIND_DOWN   = 3'd2,
    KIND_LEFT   = 3'd3,
    KIND_RIGHT  = 3'd4,
    KIND_DELETE = 3'd5
  } key_kind_e;

  typedef struct packed {
    logic shift_held;
    logic caps_on;
    logic prefix_seen;
  } flags_t;

  typedef struct packed {
    logic             emit;
    key_kind_e        kind;
    logic [CharW-1:0] ch;
  } result_t;

  function automatic logic [CharW-1:0] plain_char(input logic [IdxW-1:0] idx);
    logic [CharW-1:0] c;
    c = '0;
    case (idx)
      6'h01: c = 7'h1B;
      6'h02: c = 7'h31;
      6'h03: c = 7'h32;
      6'h04: c = 7'h33;
      6'h05: c = 7'h34;
      6'h06: c = 7'h35;
      6'h07: c = 7'h36;
      6'h08: c = 7'h37;
      6'h09: c = 7'h38;
      6'h0A: c = 7'h39;
      6'h0B: c = 7'h30;
      6'h0C: c = 7'h2D;
      6'h0D: c = 7'h3D;
      6'h0E: c = 7'h08;
      6'h0F: c = 7'h09;
      6'h10: c = 7'h71;
      6'h11: c = 7'h77;
      6'h12: c = 7'h65;
      6'h13: c = 7'h72;
      6'h14: c = 7'h74;
      6'h15: c = 7'h79;
      6'h16: c = 7'h75;
      6'h17: c = 7'h69;
      6'h18: c = 7'h6F;
      6'h19: c = 7'h70;
      6'h1A: c = 7'h5B;
      6'h1B: c = 7'h5D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h61;
      6'h1F: c = 7'h73;
      6'h20: c = 7'h64;
      6'h21: c = 7'h66;
      6'h22: c = 7'h67;
      6'h23: c = 7'h68;
      6'h24: c = 7'h6A;
      6'h25: c = 7'h6B;
      6'h26: c = 7'h6C;
      6'h27: c = 7'h3B;
      6'h28: c = 7'h27;
      6'h29: c = 7'h60;
      6'h2B: c = 7'h5C;
      6'h2C: c = 7'h7A;
      6'h2D: c = 7'h78;
      6'h2E: c = 7'h63;
      6'h2F: c = 7'h76;
      6'h30: c = 7'h62;
      6'h31: c = 7'h6E;
      6'h32: c = 7'h6D;
      6'h33: c = 7'h2C;
      6'h34: c = 7'h2E;
      6'h35: c = 7'h2F;
      6'h37: c = 7'h2A;
      6'h39: c = 7'h20;
      default: c = '0;
    endcase
    return c;
  endfunction

  // shifted symbols for keys that are not letters
  function automatic logic [CharW-1:0] shift_symbol(input logic [IdxW-1:0] idx,
                                                     input logic [CharW-1:0] plain);
    logic [CharW-1:0] c;
    c = plain;
    case (idx)
      6'h02: c = 7'h21;
      6'h03: c = 7'h40;
      6'h04: c = 7'h23;
      6'h05: c = 7'h24;
      6'h06: c = 7'h25;
      6'h07: c = 7'h5E;
      6'h08: c = 7'h26;
      6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;
      6'h0B: c = 7'h29;
      6'h0C: c = 7'h5F;
      6'h0D: c = 7'h2B;
      6'h1A: c = 7'h7B;
      6'h1B: c = 7'h7D;
      6'h27: c = 7'h3A;
      6'h28: c = 7'h22;
      6'h29: c = 7'h7E;
      6'h2B: c = 7'h7C;
      6'h33: c = 7'h3C;
      6'h34: c = 7'h3E;
      6'h35: c = 7'h3F;
      default: c = plain;
    endcase
    return c;
  endfunction

  function automatic logic [CharW-1:0] char_lookup(input logic [IdxW-1:0] idx,
                                                    input logic shift,
                                                    input logic caps);
    logic [CharW-1:0] plain;
    logic             letter;
    logic [CharW-1:0] c;
    plain  = plain_char(idx);
    letter = (plain >= 7'h61) && (plain <= 7'h7A);
    if (letter) begin
      c = (shift ^ caps) ? (plain - CaseDelta) : plain;
    end else if (shift) begin
      c = shift_symbol(idx, plain);
    end else begin
      c = plain;
    end
    return c;
  endfunction

endpackage

// File: rtl/core/sc2a_ram.sv
module sc2a_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/sc2a_decode.sv
module sc2a_decode (
  input  logic [sc2a_pkg::CodeW-1:0] code_i,
  input  sc2a_pkg::flags_t           flags_i,
  output sc2a_pkg::flags_t           flags_o,
  output sc2a_pkg::result_t          res_o
);

  logic [sc2a_pkg::CodeW-1:0] key;
  logic [sc2a_pkg::CharW-1:0] ch;

  assign key = code_i & sc2a_pkg::CodeKeyMask;
  assign ch  = sc2a_pkg::char_lookup(code_i[sc2a_pkg::IdxW-1:0], flags_i.shift_held,
                                     flags_i.caps_on);

  always_comb begin
    flags_o    = flags_i;
    res_o.emit = 1'b0;
    res_o.kind = sc2a_pkg::KIND_CHAR;
    res_o.ch   = '0;
    priority if (code_i == sc2a_pkg::CodePrefix) begin
      flags_o.prefix_seen = 1'b1;
    end else if ((code_i & sc2a_pkg::CodeRelBit) != '0) begin
      if (flags_i.prefix_seen) begin
        flags_o.prefix_seen = 1'b0;
      end else if (key == sc2a_pkg::CodeLShift || key == sc2a_pkg::CodeRShift) begin
        flags_o.shift_held = 1'b0;
      end
    end else if (flags_i.prefix_seen) begin
      flags_o.prefix_seen = 1'b0;
      res_o.emit          = 1'b1;
      priority if (code_i == sc2a_pkg::CodeUp) begin
        res_o.kind = sc2a_pkg::KIND_UP;
      end else if (code_i == sc2a_pkg::CodeDown) begin
        res_o.kind = sc2a_pkg::KIND_DOWN;
      end else if (code_i == sc2a_pkg::CodeLeft) begin
        res_o.kind = sc2a_pkg::KIND_LEFT;
      end else if (code_i == sc2a_pkg::CodeRight) begin
        res_o.kind = sc2a_pkg::KIND_RIGHT;
      end else if (code_i == sc2a_pkg::CodeDelete) begin
        res_o.kind = sc2a_pkg::KIND_DELETE;
      end else begin
        res_o.emit = 1'b0;
      end
    end else if (code_i == sc2a_pkg::CodeLShift || code_i == sc2a_pkg::CodeRShift) begin
      flags_o.shift_held = 1'b1;
    end else if (code_i == sc2a_pkg::CodeCaps) begin
      flags_o.caps_on = ~flags_i.caps_on;
    end else if (code_i < sc2a_pkg::TableLen) begin
      res_o.ch   = ch;
      res_o.emit = (ch != '0);
    end
  end

endmodule

// File: rtl/core/scancode_to_ascii_decoder.sv
// the scancode is registered in stage s1, then decoded and registered in the output
// register when s1 advances, which waits while a pending output is not taken;
// one scancode per cycle unless the output stalls, flag ram rmw overlaps by forwarding
// a scancode that yields no character or navigation key gives no output transaction
// reset clears the pipeline and the flag-valid bit, so flags read as all zero
// until the first write; the flag ram itself is not cleared
module scancode_to_ascii_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // scancode[7:0]
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // char_code[6:0], zero[7]
  output logic [2:0] m_axis_tuser_o    // key_kind[2:0]
);

  localparam int unsigned AddrW = $clog2(sc2a_pkg::FlagDepth);
  localparam logic [AddrW-1:0] FlagAddr = '0;

  logic                       in_fire;
  logic                       b_adv;
  logic                       s1_valid_q, s1_valid_d;
  logic [sc2a_pkg::CodeW-1:0] s1_code_q;
  logic                       fwd_q;
  sc2a_pkg::flags_t           fwd_data_q;
  logic                       st_valid_q;
  sc2a_pkg::flags_t           ram_rdata;
  sc2a_pkg::flags_t           flags_cur;
  sc2a_pkg::flags_t           flags_nxt;
  sc2a_pkg::result_t          res;
  logic                       out_valid_q, out_valid_d;
  sc2a_pkg::key_kind_e        out_kind_q;
  logic [sc2a_pkg::CharW-1:0] out_char_q;

  assign b_adv           = s1_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !s1_valid_q || b_adv;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;

  sc2a_ram #(
    .Width ($bits(sc2a_pkg::flags_t)),
    .Depth (sc2a_pkg::FlagDepth)
  ) u_flag_ram (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (FlagAddr),
    .wdata_i (flags_nxt),
    .re_i    (in_fire),
    .raddr_i (FlagAddr),
    .rdata_o (ram_rdata)
  );

  // write in the read cycle is forwarded
  always_comb begin
    if (fwd_q) begin
      flags_cur = fwd_data_q;
    end else if (st_valid_q) begin
      flags_cur = ram_rdata;
    end else begin
      flags_cur = '0;
    end
  end

  sc2a_decode u_decode (
    .code_i  (s1_code_q),
    .flags_i (flags_cur),
    .flags_o (flags_nxt),
    .res_o   (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (b_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (b_adv) begin
      out_valid_d = res.emit;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (b_adv) begin
        st_valid_q <= 1'b1;
      end
      if (in_fire) begin
        fwd_q <= b_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_code_q  <= s_axis_tdata_i;
      fwd_data_q <= flags_nxt;
    end
    if (b_adv) begin
      out_kind_q <= res.kind;
      out_char_q <= res.ch;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_char_q};
  assign m_axis_tuser_o  = out_kind_q;

`ifndef ASSERT_OFF
  a_fwd_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(fwd_q) |-> $past(in_fire && b_adv))
    else $error("forward flag set without overlapping write");

  a_state_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_adv |=> st_valid_q)
    else $error("flag word not marked valid after write");

  a_nav_no_char: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q != sc2a_pkg::KIND_CHAR) |-> (out_char_q == '0))
    else $error("navigation result carries a character");

  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_kind_q == sc2a_pkg::KIND_CHAR) |-> (out_char_q != '0))
    else $error("character result is zero");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready_i |=> out_valid_q && $stable(out_char_q))
    else $error("pending result lost");
`endif

endmodule
